// ----- rtl/core/clock_page_replacement_assert.svh -----
// Assertion macros for the clock page replacement block.
`ifndef CLOCK_PAGE_REPLACEMENT_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_ASSERT_SVH

// condition holds at every edge out of reset
`define CPR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CPR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define CPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/cpr_pkg.sv -----
// Types and fixed widths for the clock page replacement block.
package cpr_pkg;

   localparam int FIU_W     = 4;       // frames-in-use register
   localparam int FRAME_W   = 3;       // frame field of a response word
   localparam int COUNT_W   = 16;      // fault count
   localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SWEEP,
      ST_RESP
   } cpr_state_type;

endpackage

// ----- rtl/core/cpr_if.sv -----
// Request and response channel interfaces for the clock page replacement block.
interface cpr_req_if import cpr_pkg::*; #(parameter int PAGE_BITS = 16) ();
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page;
   logic                 first;

   modport source (output valid, output page, output first, input ready);
   modport sink   (input valid, input page, input first, output ready);
endinterface

interface cpr_rsp_if import cpr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               fault;
   logic [FRAME_W-1:0] frame;
   logic [COUNT_W-1:0] fault_count;

   modport source (output valid, output fault, output frame, output fault_count, input ready);
   modport sink   (input valid, input fault, input frame, input fault_count, output ready);
endinterface

// ----- rtl/core/clock_page_replacement.sv -----
// Clock (second-chance) page replacement: one reference word in, one response word out.
// One word at a time: the frame search reads one page-table entry per cycle, and the next
// request is taken only once the response has been accepted and the block is idle again.
// Reset (synchronous): frames invalid, reference bits, hand and count clear, frames in use 8.
module clock_page_replacement import cpr_pkg::*; #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [FIU_W-1:0] csr_wr_data,
   cpr_req_if.sink          req_ch,
   cpr_rsp_if.source        rsp_ch
);

   localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;   // frame index
   localparam int CNT_W  = $clog2(FRAMES + 1);                  // holds FRAMES itself

   // ---------------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------------
   cpr_state_type        state_ff, state_in;
   logic [FIU_W-1:0]     fiu_ff;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [FRAMES-1:0]    valid_ff, valid_in;
   logic [FRAMES-1:0]    ref_ff, ref_in;
   logic [FIDX_W-1:0]    hand_ff, hand_in;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;      // next entry to read
   logic [FIDX_W-1:0]    cmp_idx_ff, cmp_idx_in; // entry whose data sits in rd_data_ff
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 fault_ff, fault_in;
   logic [FIDX_W-1:0]    slot_ff, slot_in;

   // page table: one read port for the search, one write for a load
   logic [PAGE_BITS-1:0] page_mem [FRAMES];
   logic [PAGE_BITS-1:0] rd_data_ff;

   // ---------------------------------------------------------------------------
   // datapath helpers
   // ---------------------------------------------------------------------------
   logic [CNT_W-1:0]  active_n;     // frames in use, clamped to 1..FRAMES
   logic [CNT_W-1:0]  hand_inc;
   logic [FIDX_W-1:0] hand_next;    // hand advanced with wrap
   logic [FIDX_W-1:0] scan_idx;
   logic              req_take, rsp_take;
   logic              scan_go, hit_now, miss_now, load_now;

   always_comb begin
      if (fiu_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (int'(fiu_ff) > FRAMES) begin
         active_n = CNT_W'(FRAMES);
      end else begin
         active_n = CNT_W'(fiu_ff);
      end
   end

   assign hand_inc  = CNT_W'(hand_ff) + CNT_W'(1);
   assign hand_next = (hand_inc < active_n) ? hand_inc[FIDX_W-1:0] : '0;
   assign scan_idx  = scan_ff[FIDX_W-1:0];

   assign req_take = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_take = rsp_ch.ready && (state_ff == ST_RESP);

   // search compares the entry read in the previous cycle while the next one is read
   assign hit_now  = (state_ff == ST_SEARCH) && cmp_vld_ff && valid_ff[cmp_idx_ff]
                     && (rd_data_ff == page_ff);
   assign miss_now = (state_ff == ST_SEARCH) && !cmp_vld_ff && (scan_ff >= active_n);
   assign scan_go  = (state_ff == ST_SEARCH) && (scan_ff < active_n) && !hit_now;
   // sweep stops on the first clear reference bit and loads there
   assign load_now = (state_ff == ST_SWEEP) && !ref_ff[hand_ff];

   // ---------------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (hit_now) begin
               state_in = ST_RESP;
            end else if (miss_now) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (load_now) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // sequencer: outputs to the channels
   // ---------------------------------------------------------------------------
   always_comb begin
      req_ch.ready       = (state_ff == ST_IDLE);
      rsp_ch.valid       = (state_ff == ST_RESP);
      rsp_ch.fault       = fault_ff;
      rsp_ch.frame       = FRAME_W'(slot_ff);
      rsp_ch.fault_count = total_ff;
   end

   // ---------------------------------------------------------------------------
   // next values of the policy state
   // ---------------------------------------------------------------------------
   always_comb begin
      page_in    = page_ff;
      valid_in   = valid_ff;
      ref_in     = ref_ff;
      hand_in    = hand_ff;
      total_in   = total_ff;
      scan_in    = scan_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = 1'b0;
      fault_in   = fault_ff;
      slot_in    = slot_ff;

      if (req_take) begin
         page_in = req_ch.page;
         scan_in = '0;
         if (req_ch.first) begin
            valid_in = '0;
            ref_in   = '0;
            total_in = '0;
         end
         // hand to zero on a first request, or when left beyond the frames in use after the register shrank
         if (req_ch.first || (CNT_W'(hand_ff) >= active_n)) hand_in = '0;
      end

      if (scan_go) begin
         cmp_vld_in = 1'b1;
         cmp_idx_in = scan_idx;
         scan_in    = scan_ff + CNT_W'(1);
      end

      if (hit_now) begin
         ref_in[cmp_idx_ff] = 1'b1;
         fault_in           = 1'b0;
         slot_in            = cmp_idx_ff;
      end

      if (miss_now && (total_ff != '1)) total_in = total_ff + COUNT_W'(1);

      if (state_ff == ST_SWEEP) begin
         if (ref_ff[hand_ff]) begin
            ref_in[hand_ff] = 1'b0;   // second chance used up
         end else begin
            valid_in[hand_ff] = 1'b1;
            ref_in[hand_ff]   = 1'b1;
            slot_in           = hand_ff;
            fault_in          = 1'b1;
         end
         hand_in = hand_next;
      end
   end

   // ---------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fiu_ff     <= FIU_RESET;
         valid_ff   <= '0;
         ref_ff     <= '0;
         hand_ff    <= '0;
         total_ff   <= '0;
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         if (csr_wr_en) fiu_ff <= csr_wr_data;
         valid_ff   <= valid_in;
         ref_ff     <= ref_in;
         hand_ff    <= hand_in;
         total_ff   <= total_in;
         scan_ff    <= scan_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      cmp_idx_ff <= cmp_idx_in;
      fault_ff   <= fault_in;
      slot_ff    <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (scan_go) rd_data_ff <= page_mem[scan_idx];
      if (load_now) page_mem[hand_ff] <= page_ff;
   end

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
`include "clock_page_replacement_assert.svh"

   `CPR_ASSERT_SAME(a_resp_slot_live, state_ff == ST_RESP,
      valid_ff[slot_ff] && ref_ff[slot_ff], "response frame not loaded and referenced")
   `CPR_ASSERT_NEXT(a_sweep_clears, (state_ff == ST_SWEEP) && ref_ff[hand_ff],
      (state_ff == ST_SWEEP) && !ref_ff[$past(hand_ff)], "sweep did not clear reference bit")
   `CPR_ASSERT_NEXT(a_count_quiet, (state_ff != ST_SEARCH) && !req_take,
      $stable(total_ff), "fault count moved outside search")
   `CPR_ASSERT_ALWAYS(a_one_side, !(req_ch.ready && rsp_ch.valid),
      "request ready while response pending")

endmodule
